[rtl/core/sibs_pkg.sv]
package sibs_pkg;

    // Fixed field widths of the item and register formats.
    localparam int ID_W      = 32;
    localparam int SEL_W     = 2;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int NUM_TABLE = 4;

    // Command codes carried in the cmd field.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Input beat: one write or one lookup.
    typedef struct packed {
        logic                     cmd;
        logic [SEL_W-1:0]         table_sel;
        logic [SLOT_W-1:0]        entry_index;
        logic signed [ID_W-1:0]   id_value;
    } t_in_beat;

    // Output beat: one lookup result.
    typedef struct packed {
        logic                     found;
        logic [SLOT_W-1:0]        match_index;
    } t_out_beat;

    // Search sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_HOLD
    } t_state;

    // Write strobe toward the table memory.
    typedef struct packed {
        logic                     we;
        logic [SEL_W-1:0]         sel;
        logic [31:0]              slot;
        logic [ID_W-1:0]          data;
    } t_wr_req;

endpackage

[rtl/core/sibs_ram.sv]
module sibs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sibs_regs.sv]
module sibs_regs #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    input  logic [sibs_pkg::SEL_W-1:0]            i_sel,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      o_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = (CW > sibs_pkg::COUNT_W) ? CW + 1 : sibs_pkg::COUNT_W + 1;

    logic [sibs_pkg::COUNT_W-1:0] r_count [sibs_pkg::NUM_TABLE];
    logic [sibs_pkg::SEL_W-1:0]   reg_idx;
    logic [EW-1:0]                count_ext;

    assign reg_idx = paddr[3:2];

    // Count registers, written on the access phase of an APB write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sibs_pkg::NUM_TABLE; i++) begin
                r_count[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_count[reg_idx] <= pwdata[sibs_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = 32'(r_count[reg_idx]);

    // Count of the selected table, saturated at the table depth.
    always_comb begin
        count_ext = EW'(r_count[i_sel]);
        if (count_ext > EW'(TABLE_DEPTH)) begin
            o_count = CW'(TABLE_DEPTH);
        end else begin
            o_count = CW'(count_ext);
        end
    end

endmodule

[rtl/core/sibs_search.sv]
module sibs_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  sibs_pkg::t_in_beat                          i_in_beat,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output sibs_pkg::t_out_beat                         o_out_beat,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]            i_count,
    output sibs_pkg::t_wr_req                           o_wr,
    output logic [sibs_pkg::SEL_W+$clog2(TABLE_DEPTH)-1:0] o_raddr,
    input  logic [sibs_pkg::ID_W-1:0]                   i_rdata
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    sibs_pkg::t_state              r_state, n_state;
    logic [CW-1:0]                 r_low, n_low;
    logic [CW-1:0]                 r_hi, n_hi;
    logic [IW-1:0]                 r_mid, n_mid;
    logic signed [sibs_pkg::ID_W-1:0] r_key, n_key;
    logic [sibs_pkg::SEL_W-1:0]    r_sel, n_sel;
    sibs_pkg::t_out_beat           r_res, n_res;
    logic                          r_out_valid, n_out_valid;
    sibs_pkg::t_out_beat           r_out_beat, n_out_beat;

    logic                          accept;
    logic                          done;
    sibs_pkg::t_out_beat           res;
    logic signed [sibs_pkg::ID_W-1:0] probe;
    logic                          hit;
    logic                          less;
    logic [CW-1:0]                 low2;
    logic [CW-1:0]                 hi2;
    logic [31:0]                   mid_wide;

    // Midpoint of the half-open window [low, hi), i.e. floor((low + hi - 1) / 2).
    function automatic logic [IW-1:0] mid_of(input logic [CW-1:0] low,
                                             input logic [CW-1:0] hi);
        logic [CW:0] sum;
        sum = (CW+1)'(low) + (CW+1)'(hi) - (CW+1)'(1);
        return IW'(sum >> 1);
    endfunction

    assign accept     = i_in_valid && (r_state == sibs_pkg::ST_IDLE);
    assign o_in_stall = (r_state != sibs_pkg::ST_IDLE);

    // Table write from a write beat; slots past the depth are dropped.
    always_comb begin
        o_wr.we   = accept && (i_in_beat.cmd == sibs_pkg::CMD_WRITE)
                    && (32'(i_in_beat.entry_index) < 32'(TABLE_DEPTH));
        o_wr.sel  = i_in_beat.table_sel;
        o_wr.slot = 32'(i_in_beat.entry_index);
        o_wr.data = i_in_beat.id_value;
    end

    // Probe compare on the entry read in the previous cycle.
    assign probe    = $signed(i_rdata);
    assign hit      = (probe == r_key);
    assign less     = (probe < r_key);
    assign low2     = less ? CW'(r_mid) + CW'(1) : r_low;
    assign hi2      = less ? r_hi : CW'(r_mid);
    assign mid_wide = 32'(r_mid);

    // Sequencer: start, one probe a cycle, then hand the result to the output register.
    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_sel       = r_sel;
        n_res       = r_res;
        done        = 1'b0;
        res         = r_res;
        o_raddr     = {r_sel, r_mid};
        n_out_valid = r_out_valid && i_out_stall;
        n_out_beat  = r_out_beat;

        case (r_state)
            sibs_pkg::ST_IDLE: begin
                n_mid   = mid_of('0, i_count);
                o_raddr = {i_in_beat.table_sel, n_mid};
                if (accept && (i_in_beat.cmd == sibs_pkg::CMD_LOOKUP)) begin
                    n_low = '0;
                    n_hi  = i_count;
                    n_key = i_in_beat.id_value;
                    n_sel = i_in_beat.table_sel;
                    if (i_count == '0) begin
                        done = 1'b0;
                        res  = '{found: 1'b0, match_index: '0};
                        done = 1'b1;
                    end else begin
                        n_state = sibs_pkg::ST_PROBE;
                    end
                end
            end
            sibs_pkg::ST_PROBE: begin
                n_low   = low2;
                n_hi    = hi2;
                n_mid   = mid_of(low2, hi2);
                o_raddr = {r_sel, n_mid};
                if (hit) begin
                    res  = '{found: 1'b1, match_index: mid_wide[sibs_pkg::SLOT_W-1:0]};
                    done = 1'b1;
                end else if (low2 >= hi2) begin
                    res  = '{found: 1'b0, match_index: '0};
                    done = 1'b1;
                end
            end
            sibs_pkg::ST_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_beat  = r_res;
                    n_state     = sibs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sibs_pkg::ST_IDLE;
            end
        endcase

        // A finished search goes out now if the output register is free, else it waits.
        if (done) begin
            if (!r_out_valid || !i_out_stall) begin
                n_out_valid = 1'b1;
                n_out_beat  = res;
                n_state     = sibs_pkg::ST_IDLE;
            end else begin
                n_res   = res;
                n_state = sibs_pkg::ST_HOLD;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sibs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Search window and result payload.
    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_key      <= n_key;
        r_sel      <= n_sel;
        r_res      <= n_res;
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

[rtl/core/sorted_id_binary_search.sv]
// Channel   Direction  Handshake                       Payload
// in        input      i_in_valid / o_in_stall         i_in_beat  (t_in_beat)
// out       output     o_out_valid / i_out_stall       o_out_beat (t_out_beat)
// config    input      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A lookup makes at most log2(TABLE_DEPTH) + 1 probes, one probe per cycle; the one read
// port of the table memory sets this. Lookups are worked one at a time.
// Reset is synchronous and active low; it clears the counts and the handshake state,
// while the table memory is left undefined until written.
// A finished result waits in the output register while the next beat is accepted; a
// second result that finds the register full holds the input stalled until it drains.
module sorted_id_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sibs_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sibs_pkg::t_out_beat o_out_beat
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int AW = sibs_pkg::SEL_W + IW;

    logic [CW-1:0]               count;
    sibs_pkg::t_wr_req           wr;
    logic [AW-1:0]               raddr;
    logic [AW-1:0]               waddr;
    logic [sibs_pkg::ID_W-1:0]   rdata;

    assign pready = 1'b1;

    // Count registers and saturation for the table named by the incoming beat.
    sibs_regs #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .i_sel   (i_in_beat.table_sel),
        .o_count (count)
    );

    // Binary search sequencer and output register.
    sibs_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_count     (count),
        .o_wr        (wr),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // The four tables share one memory, addressed by table select and slot.
    assign waddr = {wr.sel, wr.slot[IW-1:0]};

    sibs_ram #(
        .WIDTH(sibs_pkg::ID_W),
        .DEPTH(1 << AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (waddr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

[sim/tb_sorted_id_binary_search.sv]
module tb_sorted_id_binary_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int NUM_PHASE = 5;
    localparam int DRAIN_CYCLES = 30;
    localparam bit signed [sibs_pkg::ID_W-1:0] ID_MIN = 32'sh8000_0000;
    localparam bit signed [sibs_pkg::ID_W-1:0] ID_MAX = 32'sh7fff_ffff;

    // Table codes carried in the table_sel field.
    typedef enum logic [sibs_pkg::SEL_W-1:0] {
        TBL_SECTION,
        TBL_ZONE,
        TBL_OBSTACLE,
        TBL_POINT
    } t_table;

    // Count register indexes, one per table, at byte address 4 * index.
    typedef enum int {
        REG_SECTION_COUNT,
        REG_ZONE_COUNT,
        REG_OBSTACLE_COUNT,
        REG_POINT_COUNT
    } t_reg;

    // Shadow of the ID tables and counts, and the queue of lookup answers still due.
    class lookup_scoreboard;
        bit signed [sibs_pkg::ID_W-1:0] id_mem [sibs_pkg::NUM_TABLE][DEPTH];
        bit                   written [sibs_pkg::NUM_TABLE][DEPTH];
        bit [sibs_pkg::COUNT_W-1:0] count [sibs_pkg::NUM_TABLE];
        sibs_pkg::t_out_beat  answers_due [$];
        int errors;
        int writes;
        int lookups;
        int hits;
        int checked;

        function int eff_count(int tbl);
            return (count[tbl] > DEPTH) ? DEPTH : int'(count[tbl]);
        endfunction

        function bit prefix_written(int tbl, int n);
            for (int i = 0; i < n; i++) begin
                if (!written[tbl][i]) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_config(t_reg idx, bit [sibs_pkg::COUNT_W-1:0] val);
            count[int'(idx)] = val;
        endfunction

        // Plain binary search over the first count slots, stepping past mid.
        function sibs_pkg::t_out_beat search(int tbl, bit signed [sibs_pkg::ID_W-1:0] key);
            int lo;
            int hi;
            int mid;
            sibs_pkg::t_out_beat res;
            res = '0;
            lo = 0;
            hi = eff_count(tbl) - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (id_mem[tbl][mid] == key) begin
                    res.found = 1'b1;
                    res.match_index = mid[sibs_pkg::SLOT_W-1:0];
                    return res;
                end
                if (id_mem[tbl][mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            return res;
        endfunction

        function void note_beat(sibs_pkg::t_in_beat b);
            sibs_pkg::t_out_beat res;
            if (b.cmd == sibs_pkg::CMD_WRITE) begin
                id_mem[b.table_sel][b.entry_index] = b.id_value;
                written[b.table_sel][b.entry_index] = 1'b1;
                writes++;
            end else begin
                res = search(b.table_sel, b.id_value);
                answers_due = {answers_due, res};
                lookups++;
                if (res.found) begin
                    hits++;
                end
            end
        endfunction

        function void check_result(sibs_pkg::t_out_beat got);
            sibs_pkg::t_out_beat want;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result found=%0b match_index=%0d",
                         $time, got.found, got.match_index);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            checked++;
            if (got.found !== want.found) begin
                $display("%0t: found mismatch, expected %0b, actual %0b",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.match_index !== want.match_index) begin
                $display("%0t: match_index mismatch, expected %0d, actual %0d",
                         $time, want.match_index, got.match_index);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    sibs_pkg::t_in_beat  i_in_beat;
    logic        o_out_valid;
    logic        i_out_stall;
    sibs_pkg::t_out_beat o_out_beat;

    lookup_scoreboard sb;
    int sender_idle_pct;
    int stall_pct;
    int settings_run;

    // Count settings per phase, in register order, and the idling of each phase.
    int phase_counts [NUM_PHASE][sibs_pkg::NUM_TABLE] = '{
        '{7, 16, 1, 0},
        '{31, 3, 100, 2},
        '{1024, 5, 12, 64},
        '{2047, 9, 50, 9},
        '{13, 0, 2, 40}
    };
    int phase_idle [NUM_PHASE]  = '{0, 86, 0, 21, 50};
    int phase_stall [NUM_PHASE] = '{0, 0, 86, 21, 50};
    int phase_items [NUM_PHASE] = '{80, 80, 80, 80, 80};

    sorted_id_binary_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stalls are redrawn every falling edge.
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Every result beat taken by the receiver is checked against the oldest answer due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_beat);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #10ms;
        $display("sorted_id_binary_search test failed");
        $finish;
    end

    // Write one count register through the APB port, then read it back.
    task automatic write_count(t_reg idx, bit [sibs_pkg::COUNT_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(4 * int'(idx));
        pwdata <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.note_config(idx, val);
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(val)) begin
            $display("%0t: register %s read back, expected %0d, actual %0d",
                     $time, idx.name(), val, prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drive one input beat from a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(sibs_pkg::t_in_beat b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(b);
        @(negedge i_clk);
    endtask

    task automatic send_write(int tbl, int slot, bit signed [sibs_pkg::ID_W-1:0] val);
        sibs_pkg::t_in_beat b;
        b.cmd = sibs_pkg::CMD_WRITE;
        b.table_sel = sibs_pkg::SEL_W'(tbl);
        b.entry_index = sibs_pkg::SLOT_W'(slot);
        b.id_value = val;
        send_beat(b);
    endtask

    task automatic send_lookup(int tbl, bit signed [sibs_pkg::ID_W-1:0] key);
        sibs_pkg::t_in_beat b;
        b.cmd = sibs_pkg::CMD_LOOKUP;
        b.table_sel = sibs_pkg::SEL_W'(tbl);
        b.entry_index = sibs_pkg::SLOT_W'($urandom);
        b.id_value = key;
        send_beat(b);
    endtask

    // Hold the sender off until every lookup answer has come back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.answers_due.size() != 0);
    endtask

    // Idle point for register writes: answers drained and the last write retired.
    task automatic wait_idle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Fill slots 0..n-1 with strictly ascending random IDs spread over the full range.
    task automatic fill_sorted(int tbl, int n);
        longint step;
        longint val;
        step = 64'sd4294967294 / (n + 1);
        val = -64'sd2147483648 + longint'($urandom_range(0, int'(step)));
        for (int i = 0; i < n; i++) begin
            send_write(tbl, i, val[sibs_pkg::ID_W-1:0]);
            val += longint'($urandom_range(1, int'(step)));
        end
    endtask

    // Pick a key: mostly stored IDs, some neighbors of stored IDs, some extremes and noise.
    function automatic bit signed [sibs_pkg::ID_W-1:0] pick_key(int tbl);
        int n;
        int r;
        bit signed [sibs_pkg::ID_W-1:0] stored;
        n = sb.eff_count(tbl);
        r = $urandom_range(0, 99);
        if (n > 0 && r < 80) begin
            stored = sb.id_mem[tbl][$urandom_range(0, n - 1)];
            if (r < 60) begin
                return stored;
            end
            return $urandom_range(0, 1) ? stored + 1 : stored - 1;
        end
        case ($urandom_range(0, 4))
            0: return ID_MIN;
            1: return ID_MAX;
            2: return 0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // A random write: mostly a value that keeps the table in order, now and then noise.
    task automatic random_write();
        int tbl;
        int n;
        int slot;
        longint lo;
        longint hi;
        bit signed [sibs_pkg::ID_W-1:0] val;
        tbl = $urandom_range(0, sibs_pkg::NUM_TABLE - 1);
        n = sb.eff_count(tbl);
        slot = (n > 0 && $urandom_range(0, 99) < 70) ? $urandom_range(0, n - 1)
                                                     : $urandom_range(0, DEPTH - 1);
        lo = (slot > 0 && sb.written[tbl][slot - 1]) ? longint'(sb.id_mem[tbl][slot - 1])
                                                     : longint'(ID_MIN);
        hi = (slot < DEPTH - 1 && sb.written[tbl][slot + 1])
             ? longint'(sb.id_mem[tbl][slot + 1]) : longint'(ID_MAX);
        if (lo <= hi && $urandom_range(0, 99) < 90) begin
            val = sibs_pkg::ID_W'(lo + longint'($urandom) % (hi - lo + 1));
        end else begin
            val = $urandom;
        end
        send_write(tbl, slot, val);
    endtask

    initial begin
        sb = new;
        sender_idle_pct = 0;
        stall_pct = 0;
        settings_run = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        i_out_stall = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Counts are zero after reset: every lookup misses without probing.
        send_lookup(TBL_SECTION, 0);
        send_lookup(TBL_ZONE, ID_MIN);
        send_lookup(TBL_OBSTACLE, ID_MAX);
        send_lookup(TBL_POINT, -1);

        // Small sorted tables holding the extreme IDs; the top slot is written once.
        send_write(TBL_SECTION, 0, ID_MIN);
        send_write(TBL_ZONE, 0, ID_MIN);
        send_write(TBL_ZONE, 1, ID_MAX);
        send_write(TBL_OBSTACLE, 0, ID_MIN);
        send_write(TBL_OBSTACLE, 1, -1);
        send_write(TBL_OBSTACLE, 2, 0);
        send_write(TBL_OBSTACLE, 3, 1);
        send_write(TBL_OBSTACLE, 4, ID_MAX);
        send_write(TBL_POINT, DEPTH - 1, 32'sh5555_5555);

        wait_idle();
        write_count(REG_SECTION_COUNT, 1);
        write_count(REG_ZONE_COUNT, 2);
        write_count(REG_OBSTACLE_COUNT, 5);
        write_count(REG_POINT_COUNT, 0);
        settings_run++;

        // Hits at both ends and the middle; misses between stored IDs, past the last one and in an empty table.
        send_lookup(TBL_SECTION, ID_MIN);
        send_lookup(TBL_SECTION, ID_MAX);
        send_lookup(TBL_ZONE, ID_MAX);
        send_lookup(TBL_ZONE, 0);
        send_lookup(TBL_OBSTACLE, ID_MIN);
        send_lookup(TBL_OBSTACLE, 0);
        send_lookup(TBL_OBSTACLE, ID_MAX);
        send_lookup(TBL_OBSTACLE, 2);
        send_lookup(TBL_POINT, 32'sh5555_5555);

        // Break the order of the obstacle table and search for a stored ID past the break.
        send_write(TBL_OBSTACLE, 2, ID_MAX);
        send_lookup(TBL_OBSTACLE, 1);

        // Random phases, each with its own counts and idling.
        for (int p = 0; p < NUM_PHASE; p++) begin
            wait_idle();
            for (int r = 0; r < sibs_pkg::NUM_TABLE; r++) begin
                write_count(t_reg'(r), sibs_pkg::COUNT_W'(phase_counts[p][r]));
            end
            settings_run++;
            sender_idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];

            // Every searched prefix must be written; small tables get fresh sorted data.
            for (int t = 0; t < sibs_pkg::NUM_TABLE; t++) begin
                if (sb.eff_count(t) <= 256 || !sb.prefix_written(t, sb.eff_count(t))) begin
                    fill_sorted(t, sb.eff_count(t));
                end
            end

            for (int i = 0; i < phase_items[p]; i++) begin
                if (i % 120 == 60) begin
                    hold_until_drained();
                end
                if ($urandom_range(0, 99) < 75) begin
                    send_lookup($urandom_range(0, sibs_pkg::NUM_TABLE - 1),
                                pick_key($urandom_range(0, sibs_pkg::NUM_TABLE - 1)));
                end else begin
                    random_write();
                end
            end
        end

        wait_idle();
        $display("Ran %0d count settings: %0d writes and %0d lookups, %0d of them hits.",
                 settings_run, sb.writes, sb.lookups, sb.hits);
        $display("Checked %0d results, %0d answers left over, %0d mismatches.",
                 sb.checked, sb.answers_due.size(), sb.errors);
        if (sb.errors == 0 && sb.answers_due.size() == 0) begin
            $display("sorted_id_binary_search test passed");
        end else begin
            $display("sorted_id_binary_search test failed");
        end
        $finish;
    end

endmodule
